// ===== rtl/scd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_pkg
// Types and constants shared by the scan-line class transition detector.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int CLS_W  = 3;
  localparam int CRD_W  = 12;
  localparam int PIX_W  = 11;
  localparam int MASK_W = 8;
  localparam int KIND_W = 2;
  localparam int IDX_W  = 2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // flag positions in a word's record set, in output order
  localparam int FL_POINT = 0;
  localparam int FL_END   = 1;
  localparam int FL_START = 2;
  localparam int FL_CLOSE = 3;
  localparam int FL_N     = 4;

  typedef enum logic [IDX_W-1:0] {
    REG_POINT_MASK      = 2'd0,
    REG_TRANSITION_MASK = 2'd1,
    REG_FIRST_ONLY_MASK = 2'd2,
    REG_IGNORE_CLASS    = 2'd3
  } reg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_POINT = 2'd0,
    KIND_START = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [MASK_W-1:0] point_mask;
    logic [MASK_W-1:0] transition_mask;
    logic [MASK_W-1:0] first_only_mask;
    logic [CLS_W-1:0]  ignore_class;
  } cfg_t;

  typedef struct packed {
    logic [FL_N-1:0]  flags;
    logic [CLS_W-1:0] cls;
    logic [CLS_W-1:0] ahead;
    logic [CLS_W-1:0] behind;
    logic [CLS_W-1:0] old;
    logic [CLS_W-1:0] ign;
    logic             bfc;
    logic [CRD_W-1:0] p_x;
    logic [CRD_W-1:0] p_y;
    logic [CRD_W-1:0] r_x;
    logic [CRD_W-1:0] r_y;
    logic [CRD_W-1:0] n_x;
    logic [CRD_W-1:0] n_y;
  } bun_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  typedef struct packed {
    kind_t            kind;
    logic [CLS_W-1:0] owner;
    logic [CLS_W-1:0] from_c;
    logic [CLS_W-1:0] to_c;
    logic [CLS_W-1:0] nb;
    logic [CRD_W-1:0] fx;
    logic [CRD_W-1:0] fy;
    logic [CRD_W-1:0] tx;
    logic [CRD_W-1:0] ty;
    logic             first;
    logic             last;
  } rec_t;

endpackage

// ===== rtl/scd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_front
// Takes pixel words, tracks line state and decides which records each
// pixel makes; hands a record set to the queue.
// ----------------------------------------------------------------------------
module scd_front #(
  parameter int NUM_CLASSES = 8,
  parameter int COORD_BITS  = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  scd_pkg::cfg_t              cfg,
  input  logic                       accept,
  input  logic [scd_pkg::CLS_W-1:0]  pixel_class,
  input  logic [scd_pkg::CLS_W-1:0]  ahead_class,
  input  logic [scd_pkg::CLS_W-1:0]  behind_class,
  input  logic [scd_pkg::PIX_W-1:0]  pos_x,
  input  logic [scd_pkg::PIX_W-1:0]  pos_y,
  input  logic [scd_pkg::CRD_W-1:0]  back_x,
  input  logic [scd_pkg::CRD_W-1:0]  back_y,
  input  logic [scd_pkg::CRD_W-1:0]  next_x,
  input  logic [scd_pkg::CRD_W-1:0]  next_y,
  input  logic                       line_end,
  output scd_pkg::bun_t              bundle,
  output logic                       bundle_push
);
  import scd_pkg::*;

  localparam logic [CRD_W-1:0] CMASK =
    (COORD_BITS >= CRD_W) ? {CRD_W{1'b1}} : CRD_W'((1 << COORD_BITS) - 1);

  function automatic logic has_bit(input logic [MASK_W-1:0] m, input logic [CLS_W-1:0] c);
    has_bit = (int'(c) < NUM_CLASSES) && m[c];
  endfunction

  logic [CLS_W-1:0]  previous_class, previous_class_next;
  logic [CRD_W-1:0]  previous_x, previous_x_next;
  logic [CRD_W-1:0]  previous_y, previous_y_next;
  logic              before_first_change, before_first_change_next;
  logic              line_starting, line_starting_next;
  logic [MASK_W-1:0] seen_end_mask, seen_end_mask_next;

  logic [CLS_W-1:0]  pc;
  logic [CRD_W-1:0]  rx, ry, px, py;
  logic [MASK_W-1:0] seen0, seen1;
  logic              bfc0, chg, f_point, f_end, f_start, f_close;

  always_comb begin
    pc    = line_starting ? cfg.ignore_class : previous_class;
    rx    = line_starting ? (back_x & CMASK) : previous_x;
    ry    = line_starting ? (back_y & CMASK) : previous_y;
    seen0 = line_starting ? '0 : seen_end_mask;
    bfc0  = line_starting | before_first_change;
    px    = CRD_W'(pos_x) & CMASK;
    py    = CRD_W'(pos_y) & CMASK;

    chg     = pixel_class != pc;
    f_point = has_bit(cfg.point_mask, pixel_class);
    f_end   = chg && has_bit(cfg.transition_mask, pc) &&
              !(has_bit(seen0, pc) && has_bit(cfg.first_only_mask, pc));
    seen1   = seen0 | (f_end ? (MASK_W'(1) << pc) : '0);
    f_start = chg && has_bit(cfg.transition_mask, pixel_class) &&
              !(has_bit(seen1, pixel_class) && has_bit(cfg.first_only_mask, pixel_class));
    f_close = line_end && has_bit(cfg.transition_mask, pixel_class) &&
              !(has_bit(seen1, pixel_class) && has_bit(cfg.first_only_mask, pixel_class));

    if (line_end) begin
      previous_class_next      = cfg.ignore_class;
      seen_end_mask_next       = '0;
      before_first_change_next = 1'b1;
      line_starting_next       = 1'b1;
    end else begin
      previous_class_next      = pixel_class;
      seen_end_mask_next       = seen1;
      before_first_change_next = bfc0 & ~chg;
      line_starting_next       = 1'b0;
    end
    previous_x_next = px;
    previous_y_next = py;

    bundle.flags           = '0;
    bundle.flags[FL_POINT] = f_point;
    bundle.flags[FL_END]   = f_end;
    bundle.flags[FL_START] = f_start;
    bundle.flags[FL_CLOSE] = f_close;
    bundle.cls    = pixel_class;
    bundle.ahead  = ahead_class;
    bundle.behind = behind_class;
    bundle.old    = pc;
    bundle.ign    = cfg.ignore_class;
    bundle.bfc    = bfc0;
    bundle.p_x    = px;
    bundle.p_y    = py;
    bundle.r_x    = rx;
    bundle.r_y    = ry;
    bundle.n_x    = next_x & CMASK;
    bundle.n_y    = next_y & CMASK;
    bundle_push   = accept && (f_point || f_end || f_start || f_close);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_class      <= '0;
      previous_x          <= '0;
      previous_y          <= '0;
      before_first_change <= 1'b1;
      line_starting       <= 1'b1;
      seen_end_mask       <= '0;
    end else if (accept) begin
      previous_class      <= previous_class_next;
      previous_x          <= previous_x_next;
      previous_y          <= previous_y_next;
      before_first_change <= before_first_change_next;
      line_starting       <= line_starting_next;
      seen_end_mask       <= seen_end_mask_next;
    end
  end

endmodule

// ===== rtl/scd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_queue
// Short queue of record sets between the front and the back.
// ----------------------------------------------------------------------------
module scd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scd_pkg::bun_t  wr_data,
  input  logic           pop,
  output scd_pkg::bun_t  head,
  output scd_pkg::qstat_t stat
);
  import scd_pkg::*;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);

  bun_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign stat.full  = count == QCNT_W'(QDEPTH);
  assign stat.empty = count == '0;
  assign stat.count = count;
  assign head       = mem[rd_ptr];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/scd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_back
// Holds one record set and hands its records out one word per pop.
// ----------------------------------------------------------------------------
module scd_back (
  input  logic          clk,
  input  logic          rst,
  input  scd_pkg::bun_t q_head,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output scd_pkg::rec_t rec
);
  import scd_pkg::*;

  bun_t            cur;
  logic [FL_N-1:0] rem, rem_next, sel;
  logic            take;

  always_comb begin
    sel      = rem & (~rem + 1'b1);
    rem_next = rem & ~sel;
    empty    = rem == '0;
    take     = pop && !empty;
    q_pop    = !q_empty && (empty || (take && rem_next == '0));

    rec.last = rem_next == '0;
    if (sel[FL_POINT]) begin
      rec.kind   = KIND_POINT;
      rec.owner  = cur.cls;
      rec.from_c = cur.cls;
      rec.to_c   = cur.cls;
      rec.nb     = '0;
      rec.fx     = cur.p_x;
      rec.fy     = cur.p_y;
      rec.tx     = cur.p_x;
      rec.ty     = cur.p_y;
      rec.first  = 1'b0;
    end else if (sel[FL_END]) begin
      rec.kind   = KIND_END;
      rec.owner  = cur.old;
      rec.from_c = cur.old;
      rec.to_c   = cur.cls;
      rec.nb     = cur.ahead;
      rec.fx     = cur.r_x;
      rec.fy     = cur.r_y;
      rec.tx     = cur.p_x;
      rec.ty     = cur.p_y;
      rec.first  = cur.bfc;
    end else if (sel[FL_START]) begin
      rec.kind   = KIND_START;
      rec.owner  = cur.cls;
      rec.from_c = cur.old;
      rec.to_c   = cur.cls;
      rec.nb     = cur.behind;
      rec.fx     = cur.r_x;
      rec.fy     = cur.r_y;
      rec.tx     = cur.p_x;
      rec.ty     = cur.p_y;
      rec.first  = cur.bfc;
    end else begin
      // closing END of the line
      rec.kind   = KIND_END;
      rec.owner  = cur.cls;
      rec.from_c = cur.cls;
      rec.to_c   = cur.ign;
      rec.nb     = cur.ign;
      rec.fx     = cur.p_x;
      rec.fy     = cur.p_y;
      rec.tx     = cur.n_x;
      rec.ty     = cur.n_y;
      rec.first  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (q_pop) begin
      rem <= q_head.flags;
    end else if (take) begin
      rem <= rem_next;
    end
  end

endmodule

// ===== rtl/scanline_class_transition_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_class_transition_detector
// Emits point and start/end transition records for classified scan-line
// pixels under per-class masks.
// ----------------------------------------------------------------------------
// One pixel word is taken per cycle while full is low; the front decides in
// that cycle which records (point, END, START, closing END, at most four)
// the pixel makes and pushes them as one set into a four-entry queue. The
// back hands out one record word per cycle while pop is high, so pixels
// that make more than one record slow the input; the queue absorbs
// bursts. With the queue and the back empty, a pixel's record set is
// written into the queue and then loaded into the back, which shows its
// first record. Pixels that make no record never enter the queue.
// Configuration registers are written through wr_en, wr_index and wr_data.
module scanline_class_transition_detector #(
  parameter int NUM_CLASSES = 8,
  parameter int COORD_BITS  = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [scd_pkg::IDX_W-1:0]          wr_index,
  input  logic [scd_pkg::MASK_W-1:0]         wr_data,
  input  logic                               push,
  output logic                               full,
  input  logic [scd_pkg::CLS_W-1:0]          pixel_class,
  input  logic [scd_pkg::CLS_W-1:0]          ahead_class,
  input  logic [scd_pkg::CLS_W-1:0]          behind_class,
  input  logic [scd_pkg::PIX_W-1:0]          pos_x,
  input  logic [scd_pkg::PIX_W-1:0]          pos_y,
  input  logic signed [scd_pkg::CRD_W-1:0]   back_x,
  input  logic signed [scd_pkg::CRD_W-1:0]   back_y,
  input  logic signed [scd_pkg::CRD_W-1:0]   next_x,
  input  logic signed [scd_pkg::CRD_W-1:0]   next_y,
  input  logic                               line_end,
  output logic                               empty,
  input  logic                               pop,
  output logic [scd_pkg::KIND_W-1:0]         record_kind,
  output logic [scd_pkg::CLS_W-1:0]          owner_class,
  output logic [scd_pkg::CLS_W-1:0]          from_class,
  output logic [scd_pkg::CLS_W-1:0]          to_class,
  output logic [scd_pkg::CLS_W-1:0]          neighbor_class,
  output logic signed [scd_pkg::CRD_W-1:0]   from_x,
  output logic signed [scd_pkg::CRD_W-1:0]   from_y,
  output logic signed [scd_pkg::CRD_W-1:0]   to_x,
  output logic signed [scd_pkg::CRD_W-1:0]   to_y,
  output logic                               first_flag,
  output logic                               last_of_run
);
  import scd_pkg::*;

  cfg_t   cfg;
  bun_t   f_bundle, q_head;
  logic   f_push, q_pop, accept;
  qstat_t q_stat;
  rec_t   rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_POINT_MASK:      cfg.point_mask      <= wr_data;
        REG_TRANSITION_MASK: cfg.transition_mask <= wr_data;
        REG_FIRST_ONLY_MASK: cfg.first_only_mask <= wr_data;
        REG_IGNORE_CLASS:    cfg.ignore_class    <= wr_data[CLS_W-1:0];
        default:             cfg                 <= cfg;
      endcase
    end
  end

  assign full   = q_stat.full;
  assign accept = push && !full;

  scd_front #(
    .NUM_CLASSES(NUM_CLASSES),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .pixel_class (pixel_class),
    .ahead_class (ahead_class),
    .behind_class(behind_class),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .back_x      (back_x),
    .back_y      (back_y),
    .next_x      (next_x),
    .next_y      (next_y),
    .line_end    (line_end),
    .bundle      (f_bundle),
    .bundle_push (f_push)
  );

  scd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (f_push),
    .wr_data(f_bundle),
    .pop    (q_pop),
    .head   (q_head),
    .stat   (q_stat)
  );

  scd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_head (q_head),
    .q_empty(q_stat.empty),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .rec    (rec)
  );

  assign record_kind    = rec.kind;
  assign owner_class    = rec.owner;
  assign from_class     = rec.from_c;
  assign to_class       = rec.to_c;
  assign neighbor_class = rec.nb;
  assign from_x         = rec.fx;
  assign from_y         = rec.fy;
  assign to_x           = rec.tx;
  assign to_y           = rec.ty;
  assign first_flag     = rec.first;
  assign last_of_run    = rec.last;

  a_queue_feeds_back: assert property (@(posedge clk) disable iff (rst)
    !q_stat.empty |=> !empty)
    else $error("queued record set not moved to output");

  a_point_not_first: assert property (@(posedge clk) disable iff (rst)
    (!empty && record_kind == KIND_POINT) |-> !first_flag)
    else $error("point record carries first flag");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== dv/scanline_class_transition_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_class_transition_detector_tb
// Self-checking bench: a directed table of pixels, then random scan lines
// under several register settings and idle patterns; every record word is
// compared field by field against an in-bench predictor or the table row.
// ----------------------------------------------------------------------------
module scanline_class_transition_detector_tb;
  import scd_pkg::*;

  localparam int WANT_MODEL  = 0;
  localparam int WANT_NONE   = 1;
  localparam int WANT_POINT  = 2;
  localparam int SETTLE      = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 80;
  localparam int DIR_N       = 15;
  localparam int IDLE_PCT [4]  = '{0, 54, 0, 9};
  localparam int STALL_PCT [4] = '{0, 0, 54, 9};

  typedef struct {
    logic [CLS_W-1:0]        cls;
    logic [CLS_W-1:0]        ahead;
    logic [CLS_W-1:0]        behind;
    logic [PIX_W-1:0]        px;
    logic [PIX_W-1:0]        py;
    logic signed [CRD_W-1:0] bx;
    logic signed [CRD_W-1:0] by;
    logic signed [CRD_W-1:0] nx;
    logic signed [CRD_W-1:0] ny;
    logic                    eol;
  } pixel_t;

  typedef struct {
    int cfg;
    int cls, ahead, behind;
    int px, py, bx, by, nx, ny;
    int eol;
    int want;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    wr_en = 1'b0;
  logic [IDX_W-1:0]        wr_index = '0;
  logic [MASK_W-1:0]       wr_data = '0;
  logic                    push = 1'b0;
  logic                    full;
  logic [CLS_W-1:0]        pixel_class = '0;
  logic [CLS_W-1:0]        ahead_class = '0;
  logic [CLS_W-1:0]        behind_class = '0;
  logic [PIX_W-1:0]        pos_x = '0;
  logic [PIX_W-1:0]        pos_y = '0;
  logic signed [CRD_W-1:0] back_x = '0;
  logic signed [CRD_W-1:0] back_y = '0;
  logic signed [CRD_W-1:0] next_x = '0;
  logic signed [CRD_W-1:0] next_y = '0;
  logic                    line_end = 1'b0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic [KIND_W-1:0]       record_kind;
  logic [CLS_W-1:0]        owner_class;
  logic [CLS_W-1:0]        from_class;
  logic [CLS_W-1:0]        to_class;
  logic [CLS_W-1:0]        neighbor_class;
  logic signed [CRD_W-1:0] from_x;
  logic signed [CRD_W-1:0] from_y;
  logic signed [CRD_W-1:0] to_x;
  logic signed [CRD_W-1:0] to_y;
  logic                    first_flag;
  logic                    last_of_run;

  scanline_class_transition_detector dut (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .push(push), .full(full),
    .pixel_class(pixel_class), .ahead_class(ahead_class), .behind_class(behind_class),
    .pos_x(pos_x), .pos_y(pos_y), .back_x(back_x), .back_y(back_y),
    .next_x(next_x), .next_y(next_y), .line_end(line_end),
    .empty(empty), .pop(pop),
    .record_kind(record_kind), .owner_class(owner_class),
    .from_class(from_class), .to_class(to_class), .neighbor_class(neighbor_class),
    .from_x(from_x), .from_y(from_y), .to_x(to_x), .to_y(to_y),
    .first_flag(first_flag), .last_of_run(last_of_run)
  );

  always #1 clk = ~clk;

  // detector state as seen by the predictor
  cfg_t             regs = '0;
  logic [CLS_W-1:0] prev_cls = '0;
  logic [CRD_W-1:0] prev_x = '0;
  logic [CRD_W-1:0] prev_y = '0;
  logic             pre_change = 1'b1;
  logic             line_fresh = 1'b1;
  logic [MASK_W-1:0] seen_end = '0;

  rec_t fresh_records[$];
  rec_t pending_records[$];
  rec_t head;

  int errors = 0;
  int checked = 0;
  int sent = 0;
  int quiet = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  cfg_t cfg_sets [4] = '{
    '{8'h00, 8'h00, 8'h00, 3'd0},
    '{8'h80, 8'h7E, 8'h04, 3'd0},
    '{8'hFF, 8'hFF, 8'h00, 3'd7},
    '{8'hFF, 8'hFF, 8'hFF, 3'd7}
  };

  //  cfg cls ah  bh  px    py    bx     by     nx     ny    eol want
  dir_row_t dir_rows [DIR_N] = '{
    '{0, 5, 0, 0,    0,    0,     0,     0,     0,     0, 1, WANT_NONE},
    '{1, 7, 7, 7, 2047, 2047, -2048, -2048,     0,     0, 0, WANT_POINT},
    '{1, 7, 0, 0,    0,    0,     0,     0,     0,     0, 0, WANT_POINT},
    '{1, 2, 3, 7,    1,    0,     0,     0,     0,     0, 0, WANT_MODEL},
    '{1, 2, 3, 7,    2,    0,     0,     0,     0,     0, 0, WANT_MODEL},
    '{1, 3, 2, 2,    3,    0,     0,     0,     0,     0, 0, WANT_MODEL},
    '{1, 2, 4, 3,    4,    0,     0,     0,     0,     0, 0, WANT_MODEL},
    '{1, 4, 4, 2,    5,    0,     0,     0,     0,     0, 0, WANT_MODEL},
    '{1, 4, 0, 4,    6,    0,     0,     0,  2047, -2048, 1, WANT_MODEL},
    '{1, 1, 6, 0,    1,    5,    -1,  2047,     0,     0, 0, WANT_MODEL},
    '{1, 6, 7, 1,    2,    5,     0,     0,     3,    -1, 1, WANT_MODEL},
    '{1, 7, 7, 7,    9,    9,     0,     0,     0,     0, 1, WANT_POINT},
    '{2, 0, 1, 6,    0,  100,    -1,   100,     0,     0, 0, WANT_MODEL},
    '{2, 5, 5, 0,    1,  100,     0,     0,     2,   101, 1, WANT_MODEL},
    '{2, 7, 0, 0, 2047,    0,     0,     0, -2048,  2047, 1, WANT_MODEL}
  };

  function automatic rec_t mk_rec(input kind_t k, input logic [CLS_W-1:0] owner,
                                  input logic [CLS_W-1:0] fc, input logic [CLS_W-1:0] tc,
                                  input logic [CLS_W-1:0] nb,
                                  input logic [CRD_W-1:0] fx, input logic [CRD_W-1:0] fy,
                                  input logic [CRD_W-1:0] tx, input logic [CRD_W-1:0] ty,
                                  input logic first, input logic last);
    rec_t r;
    r.kind = k;
    r.owner = owner;
    r.from_c = fc;
    r.to_c = tc;
    r.nb = nb;
    r.fx = fx;
    r.fy = fy;
    r.tx = tx;
    r.ty = ty;
    r.first = first;
    r.last = last;
    return r;
  endfunction

  function automatic bit may_move(input logic [CLS_W-1:0] c);
    return regs.transition_mask[c] && !(seen_end[c] && regs.first_only_mask[c]);
  endfunction

  function automatic void derive_records(input pixel_t p);
    logic [CRD_W-1:0] cx;
    logic [CRD_W-1:0] cy;
    cx = {1'b0, p.px};
    cy = {1'b0, p.py};
    fresh_records.delete();
    if (line_fresh) begin
      prev_cls = regs.ignore_class;
      prev_x = p.bx;
      prev_y = p.by;
      seen_end = '0;
      pre_change = 1'b1;
      line_fresh = 1'b0;
    end
    if (regs.point_mask[p.cls])
      fresh_records.insert(fresh_records.size(),
                           mk_rec(KIND_POINT, p.cls, p.cls, p.cls, '0,
                                  cx, cy, cx, cy, 1'b0, 1'b0));
    if (p.cls != prev_cls) begin
      if (may_move(prev_cls)) begin
        fresh_records.insert(fresh_records.size(),
                             mk_rec(KIND_END, prev_cls, prev_cls, p.cls, p.ahead,
                                    prev_x, prev_y, cx, cy, pre_change, 1'b0));
        seen_end[prev_cls] = 1'b1;
      end
      if (may_move(p.cls))
        fresh_records.insert(fresh_records.size(),
                             mk_rec(KIND_START, p.cls, prev_cls, p.cls, p.behind,
                                    prev_x, prev_y, cx, cy, pre_change, 1'b0));
      pre_change = 1'b0;
    end
    prev_cls = p.cls;
    prev_x = cx;
    prev_y = cy;
    if (p.eol) begin
      if (may_move(p.cls))
        fresh_records.insert(fresh_records.size(),
                             mk_rec(KIND_END, p.cls, p.cls, regs.ignore_class,
                                    regs.ignore_class, cx, cy, p.nx, p.ny,
                                    1'b1, 1'b0));
      line_fresh = 1'b1;
      prev_cls = regs.ignore_class;
      seen_end = '0;
      pre_change = 1'b1;
    end
    if (fresh_records.size() > 0)
      fresh_records[fresh_records.size() - 1].last = 1'b1;
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= 30)
      $display("mismatch at record %0d: %s", checked, msg);
  endtask

  task automatic check_field(input string name, input logic [CRD_W-1:0] got,
                             input logic [CRD_W-1:0] want);
    if (got !== want)
      report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // check each popped word, drive pop, count quiet cycles
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      quiet <= 0;
    end else begin
      if (pop && !empty) begin
        if (pending_records.size() == 0) begin
          report("record word with nothing expected");
        end else begin
          head = pending_records.pop_front();
          check_field("record_kind", record_kind, head.kind);
          check_field("owner_class", owner_class, head.owner);
          check_field("from_class", from_class, head.from_c);
          check_field("to_class", to_class, head.to_c);
          check_field("neighbor_class", neighbor_class, head.nb);
          check_field("from_x", from_x, head.fx);
          check_field("from_y", from_y, head.fy);
          check_field("to_x", to_x, head.tx);
          check_field("to_y", to_y, head.ty);
          check_field("first_flag", first_flag, head.first);
          check_field("last_of_run", last_of_run, head.last);
        end
        checked++;
      end
      if ((push && !full) || (pop && !empty) || wr_en)
        quiet <= 0;
      else
        quiet <= quiet + 1;
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_pixel(input pixel_t p, input int want);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    pixel_class <= p.cls;
    ahead_class <= p.ahead;
    behind_class <= p.behind;
    pos_x <= p.px;
    pos_y <= p.py;
    back_x <= p.bx;
    back_y <= p.by;
    next_x <= p.nx;
    next_y <= p.ny;
    line_end <= p.eol;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
    derive_records(p);
    case (want)
      WANT_MODEL: foreach (fresh_records[i])
        pending_records.insert(pending_records.size(), fresh_records[i]);
      WANT_POINT: pending_records.insert(pending_records.size(),
                                         mk_rec(KIND_POINT, p.cls, p.cls, p.cls, '0,
                                                {1'b0, p.px}, {1'b0, p.py},
                                                {1'b0, p.px}, {1'b0, p.py},
                                                1'b0, 1'b1));
      default: ;
    endcase
  endtask

  // sender holds off until every record has drained
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [MASK_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    case (idx)
      REG_POINT_MASK:      regs.point_mask = val;
      REG_TRANSITION_MASK: regs.transition_mask = val;
      REG_FIRST_ONLY_MASK: regs.first_only_mask = val;
      REG_IGNORE_CLASS:    regs.ignore_class = val[CLS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_cfg(input cfg_t c);
    set_reg(REG_POINT_MASK, c.point_mask);
    set_reg(REG_TRANSITION_MASK, c.transition_mask);
    set_reg(REG_FIRST_ONLY_MASK, c.first_only_mask);
    set_reg(REG_IGNORE_CLASS, {{(MASK_W-CLS_W){1'b0}}, c.ignore_class});
    wr_en <= 1'b0;
  endtask

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.point_mask = pick_mask();
    c.transition_mask = pick_mask();
    c.first_only_mask = pick_mask();
    c.ignore_class = CLS_W'($urandom_range(7));
    return c;
  endfunction

  // mostly well-formed lines drawn from a small class palette, some noise
  task automatic send_line();
    int len, x0, y0, k;
    bit noisy;
    logic [CLS_W-1:0] pal [3];
    logic [CLS_W-1:0] cur;
    pixel_t p;
    noisy = ($urandom_range(9) == 0);
    len = $urandom_range(1, 12);
    x0 = $urandom_range(0, 2047 - len);
    y0 = $urandom_range(0, 2047);
    foreach (pal[i]) pal[i] = CLS_W'($urandom_range(7));
    if ($urandom_range(2) == 0) pal[2] = regs.ignore_class;
    cur = pal[0];
    for (k = 0; k < len; k++) begin
      if (noisy) begin
        p.cls = CLS_W'($urandom_range(7));
        p.ahead = CLS_W'($urandom_range(7));
        p.behind = CLS_W'($urandom_range(7));
        p.px = PIX_W'($urandom);
        p.py = PIX_W'($urandom);
        p.bx = CRD_W'($urandom);
        p.by = CRD_W'($urandom);
        p.nx = CRD_W'($urandom);
        p.ny = CRD_W'($urandom);
        p.eol = ($urandom_range(3) == 0);
      end else begin
        if ($urandom_range(99) < 40) cur = pal[$urandom_range(2)];
        p.cls = cur;
        p.ahead = pal[$urandom_range(2)];
        p.behind = pal[$urandom_range(2)];
        p.px = PIX_W'(x0 + k);
        p.py = PIX_W'(y0);
        p.bx = CRD_W'(x0 + k - 1);
        p.by = CRD_W'(y0);
        p.nx = CRD_W'(x0 + k + 1);
        p.ny = CRD_W'(y0);
        p.eol = (k == len - 1);
      end
      send_pixel(p, WANT_MODEL);
    end
  endtask

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int row, ph, goal, cfg_sel;
    bit paused;
    pixel_t p;
    cfg_sel = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < DIR_N; row++) begin
      if (dir_rows[row].cfg != cfg_sel) begin
        wait_idle();
        cfg_sel = dir_rows[row].cfg;
        write_cfg(cfg_sets[cfg_sel]);
      end
      p.cls = CLS_W'(dir_rows[row].cls);
      p.ahead = CLS_W'(dir_rows[row].ahead);
      p.behind = CLS_W'(dir_rows[row].behind);
      p.px = PIX_W'(dir_rows[row].px);
      p.py = PIX_W'(dir_rows[row].py);
      p.bx = CRD_W'(dir_rows[row].bx);
      p.by = CRD_W'(dir_rows[row].by);
      p.nx = CRD_W'(dir_rows[row].nx);
      p.ny = CRD_W'(dir_rows[row].ny);
      p.eol = dir_rows[row].eol[0];
      send_pixel(p, dir_rows[row].want);
    end

    for (ph = 0; ph < 4; ph++) begin
      wait_idle();
      idle_pct = IDLE_PCT[ph];
      stall_pct = STALL_PCT[ph];
      write_cfg(ph == 1 ? cfg_sets[3] : rand_cfg());
      goal = sent + PHASE_ITEMS;
      paused = 1'b0;
      while (sent < goal) begin
        if (!paused && sent >= goal - PHASE_ITEMS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        send_line();
      end
    end

    wait_idle();
    if (errors == 0 && pending_records.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
